// ----- src/prrb_pkg.sv -----
package prrb_pkg;

  // Item modes
  localparam logic [2:0] MODE_PUSH = 3'd0;
  localparam logic [2:0] MODE_POP  = 3'd1;
  localparam logic [2:0] MODE_PEEK = 3'd2;
  localparam logic [2:0] MODE_READ = 3'd3;
  localparam logic [2:0] MODE_LEN  = 3'd4;

  localparam logic [11:0] CAPACITY_RESET = 12'd1500;
  localparam logic [15:0] COUNT_MAX      = 16'hFFFF;
  localparam int unsigned OFFSET_W       = 11;

  typedef struct packed {
    logic [2:0]  mode;
    logic [7:0]  data_byte;
    logic [11:0] record_size;
    logic        record_first;
    logic        record_last;
    logic [10:0] read_address;
  } item_t;

  typedef struct packed {
    logic        found;
    logic [10:0] offset;
    logic [7:0]  read_data;
    logic [15:0] record_count;
  } result_t;

  // Store port controls
  typedef struct packed {
    logic we;
    logic re;
  } store_req_t;

endpackage

// ----- src/padded_record_ring_buffer.sv -----
// Byte ring buffer for variable-length records that never wrap. Each command
// beat (start_i while busy_o is low) carries one operation: push one record
// byte, pop a record, peek the tail record, read a stored byte, or get the
// record count. Every beat is accepted and its result appears on
// result_o for exactly one cycle, flagged by done_o, on the cycle after the
// beat; busy_o never rises, so a new beat may be issued every clock. All
// results are registered to line up with the synchronous read port of the byte store.
// The receiver cannot stall: a result not captured in its done_o cycle is
// gone. The capacity register may only be written while no result is pending.
// Pushes that run into the tail are not checked; a byte read from an entry
// never written returns an undefined value.
module padded_record_ring_buffer import prrb_pkg::*; #(
  parameter int STORE_DEPTH = 2048
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        start_i,
  output logic        busy_o,
  input  item_t       item_i,
  output logic        done_o,
  output result_t     result_o,
  input  logic        cfg_we_i,
  input  logic [11:0] cfg_wdata_i
);

  // AW indexes the store, PW holds offsets up to STORE_DEPTH itself, and
  // SW is wide enough for head + size and tail + size + pad.
  localparam int AW = $clog2(STORE_DEPTH);
  localparam int PW = $clog2(STORE_DEPTH + 1);
  localparam int SW = ((PW > 12) ? PW : 12) + 2;

  logic          accept;
  logic [11:0]   cap_q;
  logic [SW-1:0] cap_raw;
  logic [SW-1:0] cap_eff;

  logic [PW-1:0] head_q, head_d, head_mid;
  logic [PW-1:0] tail_q, tail_d;
  logic [PW-1:0] pad_q, pad_d;
  logic [15:0]   cnt_q, cnt_d;

  logic          done_q;
  logic          found_q, found_d;
  logic [PW-1:0] off_q, off_d;
  logic          rd_sel_q, rd_sel_d;

  logic [SW-1:0] head_w, tail_w, pad_w, size_w, addr_w;
  logic [SW-1:0] off_w;

  store_req_t    st_req;
  logic [AW-1:0] st_addr;
  logic [7:0]    st_rdata;

  assign accept = start_i && !busy_o;
  assign busy_o = 1'b0;  // beats are never held off

  // Capacity clamp: 0 acts as 1, anything above the store depth as the depth
  assign cap_raw = SW'(cap_q);
  always_comb begin
    if (cap_raw == '0) begin
      cap_eff = SW'(1);
    end else if (cap_raw > SW'(STORE_DEPTH)) begin
      cap_eff = SW'(STORE_DEPTH);
    end else begin
      cap_eff = cap_raw;
    end
  end

  assign head_w = SW'(head_q);
  assign tail_w = SW'(tail_q);
  assign pad_w  = SW'(pad_q);
  assign size_w = SW'(item_i.record_size);
  assign addr_w = SW'(item_i.read_address);

  always_comb begin
    head_d   = head_q;
    head_mid = head_q;
    tail_d   = tail_q;
    pad_d    = pad_q;
    cnt_d    = cnt_q;
    found_d  = 1'b0;
    off_d    = '0;
    rd_sel_d = 1'b0;
    st_req   = '0;
    st_addr  = addr_w[AW-1:0];

    if (accept) begin
      case (item_i.mode)
        MODE_PUSH: begin
          // wrap check on the first byte: record restarts at offset 0
          if (item_i.record_first && (head_w + size_w > cap_eff)) begin
            if (cnt_q == '0) begin
              tail_d = '0;
            end else if (head_w < cap_eff) begin
              pad_d = PW'(cap_eff - head_w);
            end else begin
              pad_d = '0;
            end
            head_mid = '0;
          end
          st_addr = head_mid[AW-1:0];
          // bytes past the end of the store are dropped
          if (SW'(head_mid) < SW'(STORE_DEPTH)) begin
            st_req.we = 1'b1;
            head_d    = head_mid + PW'(1);
          end else begin
            head_d = head_mid;
          end
          if (item_i.record_last && (cnt_q != COUNT_MAX)) begin
            cnt_d = cnt_q + 16'd1;
          end
        end
        MODE_POP: begin
          if (cnt_q != '0) begin
            cnt_d   = cnt_q - 16'd1;
            found_d = 1'b1;
            off_d   = tail_q;
            // only padding left before capacity: jump to 0
            if (tail_w + size_w + pad_w >= cap_eff) begin
              tail_d = '0;
              pad_d  = '0;
            end else begin
              tail_d = PW'(tail_w + size_w);
            end
          end
        end
        MODE_PEEK: begin
          if (cnt_q != '0) begin
            found_d = 1'b1;
            off_d   = tail_q;
          end
        end
        MODE_READ: begin
          if (addr_w < SW'(STORE_DEPTH)) begin
            st_req.re = 1'b1;
            rd_sel_d  = 1'b1;
          end
        end
        default: begin
          // length and unused modes only report the count
        end
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cap_q    <= CAPACITY_RESET;
      head_q   <= '0;
      tail_q   <= '0;
      pad_q    <= '0;
      cnt_q    <= '0;
      done_q   <= 1'b0;
      found_q  <= 1'b0;
      rd_sel_q <= 1'b0;
    end else begin
      if (cfg_we_i) begin
        cap_q <= cfg_wdata_i;
      end
      head_q   <= head_d;
      tail_q   <= tail_d;
      pad_q    <= pad_d;
      cnt_q    <= cnt_d;
      done_q   <= accept;
      found_q  <= found_d;
      rd_sel_q <= rd_sel_d;
    end
  end

  always_ff @(posedge clk_i) begin
    off_q <= off_d;
  end

  prrb_store #(
    .STORE_DEPTH(STORE_DEPTH)
  ) u_store (
    .clk_i  (clk_i),
    .req_i  (st_req),
    .addr_i (st_addr),
    .wdata_i(item_i.data_byte),
    .rdata_o(st_rdata)
  );

  assign off_w = SW'(off_q);

  assign done_o                = done_q;
  assign result_o.found        = found_q;
  assign result_o.offset       = off_w[OFFSET_W-1:0];
  assign result_o.read_data    = rd_sel_q ? st_rdata : 8'd0;
  assign result_o.record_count = cnt_q;

endmodule

// ----- src/prrb_store.sv -----
module prrb_store import prrb_pkg::*; #(
  parameter int STORE_DEPTH = 2048
) (
  input  logic                           clk_i,
  input  store_req_t                     req_i,
  input  logic [$clog2(STORE_DEPTH)-1:0] addr_i,
  input  logic [7:0]                     wdata_i,
  output logic [7:0]                     rdata_o
);

  logic [7:0] mem [STORE_DEPTH];
  logic [7:0] rdata_q;

  // single port, registered read
  always_ff @(posedge clk_i) begin
    if (req_i.we) begin
      mem[addr_i] <= wdata_i;
    end
    if (req_i.re) begin
      rdata_q <= mem[addr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

// ----- src/prrb_checker.sv -----
module prrb_checker import prrb_pkg::*; (
  input logic    clk_i,
  input logic    rst_ni,
  input logic    start_i,
  input logic    busy_o,
  input logic    done_o,
  input result_t result_o
);

  // every accepted beat yields a result on the next cycle
  a_done_follows: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (start_i && !busy_o) |=> done_o)
    else $error("accepted beat without result");

  // no result without a beat
  a_no_spurious: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(start_i && !busy_o) |=> !done_o)
    else $error("result without accepted beat");

  a_offset_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (done_o && !result_o.found) |-> (result_o.offset == '0))
    else $error("offset set without found record");

  a_found_no_data: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (done_o && result_o.found) |-> (result_o.read_data == '0))
    else $error("read data on pop or peek");

  // count moves by at most one between back-to-back results
  a_count_step: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (done_o && $past(done_o)) |->
      ((result_o.record_count == $past(result_o.record_count)) ||
       (result_o.record_count == $past(result_o.record_count) + 16'd1) ||
       (result_o.record_count == $past(result_o.record_count) - 16'd1)))
    else $error("record count jumped");

endmodule

bind padded_record_ring_buffer prrb_checker u_prrb_checker (
  .clk_i   (clk_i),
  .rst_ni  (rst_ni),
  .start_i (start_i),
  .busy_o  (busy_o),
  .done_o  (done_o),
  .result_o(result_o)
);
